/* rtl/core/rdc_pkg.sv */
// Shared types and codes for the RS-485 direction controller.
package rdc_pkg;

    // Input action codes
    localparam logic [1:0] ACT_SEND  = 2'd0;
    localparam logic [1:0] ACT_DRAIN = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_DRIVE_ACTIVE_HIGH   = 3'd0;
    localparam logic [2:0] REG_RECEIVE_ACTIVE_HIGH = 3'd1;
    localparam logic [2:0] REG_RELEASE_TICKS       = 3'd2;
    localparam logic [2:0] REG_TURNAROUND_TICKS    = 3'd3;
    localparam logic [2:0] REG_DRIVE_PIN_PRESENT   = 3'd4;
    localparam logic [2:0] REG_RECEIVE_PIN_PRESENT = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Reset value of the turnaround wait
    localparam logic [7:0] TURN_RESET = 8'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] send_byte;
        logic       transmitter_empty;
    } t_req;

    typedef struct packed {
        logic       drive_pin;
        logic       receive_pin;
        logic       launch_valid;
        logic [7:0] launch_byte;
        logic       accepted;
        logic [2:0] phase_now;
    } t_res;

    typedef struct packed {
        logic        drive_active_high;
        logic        receive_active_high;
        logic [15:0] release_ticks;
        logic [7:0]  turnaround_ticks;
        logic        drive_pin_present;
        logic        receive_pin_present;
    } t_cfg;

endpackage

/* rtl/core/rdc_channels.sv */
// Valid/ready channel interfaces for requests and results.
interface rdc_req_if;
    logic          valid;
    logic          ready;
    rdc_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rdc_res_if;
    logic          valid;
    logic          ready;
    rdc_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/rs485_direction_control_unit.sv */
// Top level of the RS-485 direction controller: input and result registers.
//
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    action, send_byte, transmitter_empty
//  o_res    out  valid/ready    drive_pin, receive_pin, launch_valid,
//                               launch_byte, accepted, phase_now
//  cfg      in   i_cfg_we only  i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result register is not stalled; an item passes
// through the input register, then the phase step loads its result into the result register.
// Synchronous active-low reset returns to receive mode with default registers.
// A stalled result holds; the input register still takes one item behind it.
module rs485_direction_control_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rdc_req_if.sink                         i_req,
    rdc_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [rdc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    rdc_pkg::t_cfg cfg;
    rdc_pkg::t_req r_in_item;
    rdc_pkg::t_res r_out_res;
    rdc_pkg::t_res step_res;
    logic          r_in_valid;
    logic          r_out_valid;
    logic          advance;
    logic          step;

    rdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pipeline moves when the result register is free or being drained
    assign advance     = !r_out_valid || o_res.ready;
    assign step        = advance && r_in_valid;
    assign i_req.ready = !r_in_valid || advance;

    rdc_phase_ctrl u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_item <= i_req.payload;
        end
        if (step) begin
            r_out_res <= step_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out_res;

endmodule

/* rtl/core/rdc_cfg_regs.sv */
// Configuration register bank written through a plain write port.
module rdc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rdc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rdc_pkg::t_cfg                  o_cfg
);

    rdc_pkg::t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_active_high   <= 1'b1;
            r_cfg.receive_active_high <= 1'b0;
            r_cfg.release_ticks       <= '0;
            r_cfg.turnaround_ticks    <= rdc_pkg::TURN_RESET;
            r_cfg.drive_pin_present   <= 1'b1;
            r_cfg.receive_pin_present <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rdc_pkg::REG_DRIVE_ACTIVE_HIGH:   r_cfg.drive_active_high   <= i_cfg_data[0];
                rdc_pkg::REG_RECEIVE_ACTIVE_HIGH: r_cfg.receive_active_high <= i_cfg_data[0];
                rdc_pkg::REG_RELEASE_TICKS:       r_cfg.release_ticks       <= i_cfg_data;
                rdc_pkg::REG_TURNAROUND_TICKS:    r_cfg.turnaround_ticks    <= i_cfg_data[7:0];
                rdc_pkg::REG_DRIVE_PIN_PRESENT:   r_cfg.drive_pin_present   <= i_cfg_data[0];
                rdc_pkg::REG_RECEIVE_PIN_PRESENT: r_cfg.receive_pin_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/rdc_phase_ctrl.sv */
// Direction phase state machine: one registered step per transfer.
module rdc_phase_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  rdc_pkg::t_req i_item,
    input  rdc_pkg::t_cfg i_cfg,
    output rdc_pkg::t_res o_res
);

    typedef enum logic [2:0] {
        PH_RECEIVE   = 3'd0,
        PH_RX_OFF    = 3'd1,
        PH_DRIVE_ON  = 3'd2,
        PH_SENDING   = 3'd3,
        PH_HOLD      = 3'd4,
        PH_WATCH     = 3'd5,
        PH_DRIVE_OFF = 3'd6,
        PH_RX_ON     = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_release_count, n_release_count;
    logic [7:0]  r_turn_count, n_turn_count;
    logic [7:0]  r_held_byte, n_held_byte;

    logic        turn_nz, rx_wait, drv_wait;
    logic [7:0]  turn_dec;
    logic [15:0] release_dec;
    logic        launch;
    logic [7:0]  launch_byte;
    logic        accepted;
    logic        driving, receiving;

    assign turn_nz     = (i_cfg.turnaround_ticks != 8'd0);
    assign rx_wait     = i_cfg.receive_pin_present && turn_nz;
    assign drv_wait    = i_cfg.drive_pin_present && turn_nz;
    assign turn_dec    = r_turn_count - {7'd0, (r_turn_count != 8'd0)};
    assign release_dec = r_release_count - {15'd0, (r_release_count != 16'd0)};

    // Next phase for one item; pin changes with zero wait fall through
    always_comb begin
        n_phase         = r_phase;
        n_release_count = r_release_count;
        n_turn_count    = r_turn_count;
        n_held_byte     = r_held_byte;
        launch          = 1'b0;
        launch_byte     = 8'd0;
        accepted        = 1'b0;
        case (i_item.action)
            rdc_pkg::ACT_SEND: begin
                if (r_phase == PH_RECEIVE) begin
                    n_held_byte = i_item.send_byte;
                    accepted    = 1'b1;
                    if (rx_wait) begin
                        n_phase      = PH_RX_OFF;
                        n_turn_count = i_cfg.turnaround_ticks;
                    end else if (drv_wait) begin
                        n_phase      = PH_DRIVE_ON;
                        n_turn_count = i_cfg.turnaround_ticks;
                    end else begin
                        n_phase     = PH_SENDING;
                        launch      = 1'b1;
                        launch_byte = i_item.send_byte;
                    end
                end else if (r_phase inside {PH_SENDING, PH_HOLD, PH_WATCH}) begin
                    // pass through, cancels any pending release
                    accepted    = 1'b1;
                    n_phase     = PH_SENDING;
                    launch      = 1'b1;
                    launch_byte = i_item.send_byte;
                end
            end
            rdc_pkg::ACT_DRAIN: begin
                if (r_phase == PH_SENDING) begin
                    if (i_cfg.release_ticks != 16'd0) begin
                        n_phase         = PH_HOLD;
                        n_release_count = i_cfg.release_ticks;
                    end else begin
                        n_phase = PH_WATCH;
                    end
                end
            end
            rdc_pkg::ACT_TICK: begin
                case (r_phase)
                    PH_RX_OFF, PH_DRIVE_ON, PH_DRIVE_OFF, PH_RX_ON: begin
                        n_turn_count = turn_dec;
                        if (turn_dec == 8'd0) begin
                            case (r_phase)
                                PH_RX_OFF: begin
                                    if (drv_wait) begin
                                        n_phase      = PH_DRIVE_ON;
                                        n_turn_count = i_cfg.turnaround_ticks;
                                    end else begin
                                        n_phase     = PH_SENDING;
                                        launch      = 1'b1;
                                        launch_byte = r_held_byte;
                                    end
                                end
                                PH_DRIVE_ON: begin
                                    n_phase     = PH_SENDING;
                                    launch      = 1'b1;
                                    launch_byte = r_held_byte;
                                end
                                PH_DRIVE_OFF: begin
                                    if (rx_wait) begin
                                        n_phase      = PH_RX_ON;
                                        n_turn_count = i_cfg.turnaround_ticks;
                                    end else begin
                                        n_phase = PH_RECEIVE;
                                    end
                                end
                                default: n_phase = PH_RECEIVE;
                            endcase
                        end
                    end
                    PH_HOLD, PH_WATCH: begin
                        if (r_phase == PH_HOLD) begin
                            n_release_count = release_dec;
                        end
                        if ((r_phase == PH_HOLD && release_dec == 16'd0) ||
                            (r_phase == PH_WATCH && i_item.transmitter_empty)) begin
                            // release: driver off, then receiver on
                            if (drv_wait) begin
                                n_phase      = PH_DRIVE_OFF;
                                n_turn_count = i_cfg.turnaround_ticks;
                            end else if (rx_wait) begin
                                n_phase      = PH_RX_ON;
                                n_turn_count = i_cfg.turnaround_ticks;
                            end else begin
                                n_phase = PH_RECEIVE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Pin levels follow the phase after the step
    assign driving   = (n_phase inside {PH_DRIVE_ON, PH_SENDING, PH_HOLD, PH_WATCH});
    assign receiving = (n_phase == PH_RECEIVE) || (n_phase == PH_RX_ON);

    always_comb begin
        o_res.drive_pin    = i_cfg.drive_pin_present &&
                             (driving ? i_cfg.drive_active_high : !i_cfg.drive_active_high);
        o_res.receive_pin  = i_cfg.receive_pin_present &&
                             (receiving ? i_cfg.receive_active_high
                                        : !i_cfg.receive_active_high);
        o_res.launch_valid = launch;
        o_res.launch_byte  = launch_byte;
        o_res.accepted     = accepted;
        o_res.phase_now    = n_phase;
    end

    // State update on each transfer leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_RECEIVE;
            r_release_count <= '0;
            r_turn_count    <= '0;
            r_held_byte     <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_release_count <= n_release_count;
            r_turn_count    <= n_turn_count;
            r_held_byte     <= n_held_byte;
        end
    end

`ifndef SYNTHESIS
    // a turnaround wait always has ticks left to count
    a_turn_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RX_OFF || r_phase == PH_DRIVE_ON ||
         r_phase == PH_DRIVE_OFF || r_phase == PH_RX_ON) |-> (r_turn_count != 8'd0))
        else $error("turnaround phase with zero count");

    // the release hold always has ticks left to count
    a_hold_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HOLD) |-> (r_release_count != 16'd0))
        else $error("hold phase with zero release count");

    // a launch always leaves the block in sending
    a_launch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && launch) |=> (r_phase == PH_SENDING))
        else $error("launch without entering sending");

    // a send taken in receive mode holds its byte
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_RECEIVE && i_item.action == rdc_pkg::ACT_SEND)
        |=> (r_held_byte == $past(i_item.send_byte)))
        else $error("held byte not captured");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the RS-485 direction controller: directed and random traffic.
module testbench;

    // Phase codes reported in phase_now
    localparam logic [2:0] PH_RECEIVE   = 3'd0;
    localparam logic [2:0] PH_RX_OFF    = 3'd1;
    localparam logic [2:0] PH_DRIVE_ON  = 3'd2;
    localparam logic [2:0] PH_SENDING   = 3'd3;
    localparam logic [2:0] PH_HOLD      = 3'd4;
    localparam logic [2:0] PH_WATCH     = 3'd5;
    localparam logic [2:0] PH_DRIVE_OFF = 3'd6;
    localparam logic [2:0] PH_RX_ON     = 3'd7;

    // Action code the block does not use
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 950;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rdc_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [rdc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rdc_req_if req_bus ();
    rdc_res_if status_bus ();

    rs485_direction_control_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_res       (status_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted link state and the register copy it runs on
    rdc_pkg::t_cfg link_cfg;
    logic [2:0]  link_phase;
    logic [15:0] hold_count;
    logic [7:0]  turn_left;
    logic [7:0]  saved_byte;
    logic        sent_since_drain;
    logic        fire_now;
    logic [7:0]  fire_byte;

    rdc_pkg::t_res pending_status[$];

    int items_sent;
    int results_seen;
    int launch_count;
    int refused_count;
    int error_count;
    int quiet_cycles;
    logic steady_run;
    logic status_hold;

    // ------------------------------------------------------------------
    // Direction-control predictor
    // ------------------------------------------------------------------
    function void start_launch(input logic [7:0] b);
        link_phase = PH_SENDING;
        fire_now = 1'b1;
        fire_byte = b;
        sent_since_drain = 1'b1;
    endfunction

    function void open_driver();
        if (link_cfg.drive_pin_present && link_cfg.turnaround_ticks != 0) begin
            link_phase = PH_DRIVE_ON;
            turn_left = link_cfg.turnaround_ticks;
        end else begin
            start_launch(saved_byte);
        end
    endfunction

    function void open_receiver();
        if (link_cfg.receive_pin_present && link_cfg.turnaround_ticks != 0) begin
            link_phase = PH_RX_ON;
            turn_left = link_cfg.turnaround_ticks;
        end else begin
            link_phase = PH_RECEIVE;
        end
    endfunction

    function void quiet_driver();
        if (link_cfg.drive_pin_present && link_cfg.turnaround_ticks != 0) begin
            link_phase = PH_DRIVE_OFF;
            turn_left = link_cfg.turnaround_ticks;
        end else begin
            open_receiver();
        end
    endfunction

    function automatic rdc_pkg::t_res advance_direction(input rdc_pkg::t_req r);
        rdc_pkg::t_res o;
        logic took;
        logic driving;
        logic receiving;
        took = 1'b0;
        fire_now = 1'b0;
        fire_byte = 8'h00;
        case (r.action)
            rdc_pkg::ACT_SEND: begin
                if (link_phase == PH_RECEIVE) begin
                    saved_byte = r.send_byte;
                    took = 1'b1;
                    // receiver goes off first, then the driver comes on
                    if (link_cfg.receive_pin_present && link_cfg.turnaround_ticks != 0) begin
                        link_phase = PH_RX_OFF;
                        turn_left = link_cfg.turnaround_ticks;
                    end else begin
                        open_driver();
                    end
                end else if (link_phase >= PH_SENDING && link_phase <= PH_WATCH) begin
                    took = 1'b1;
                    start_launch(r.send_byte);
                end
            end
            rdc_pkg::ACT_DRAIN: begin
                if (link_phase == PH_SENDING) begin
                    sent_since_drain = 1'b0;
                    if (link_cfg.release_ticks != 0) begin
                        link_phase = PH_HOLD;
                        hold_count = link_cfg.release_ticks;
                    end else begin
                        link_phase = PH_WATCH;
                    end
                end
            end
            rdc_pkg::ACT_TICK: begin
                case (link_phase)
                    PH_RX_OFF, PH_DRIVE_ON, PH_DRIVE_OFF, PH_RX_ON: begin
                        if (turn_left != 0) turn_left = turn_left - 8'd1;
                        if (turn_left == 0) begin
                            case (link_phase)
                                PH_RX_OFF:    open_driver();
                                PH_DRIVE_ON:  start_launch(saved_byte);
                                PH_DRIVE_OFF: open_receiver();
                                default:      link_phase = PH_RECEIVE;
                            endcase
                        end
                    end
                    PH_HOLD: begin
                        if (hold_count != 0) hold_count = hold_count - 16'd1;
                        if (hold_count == 0) quiet_driver();
                    end
                    PH_WATCH: begin
                        if (r.transmitter_empty) quiet_driver();
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        driving = (link_phase >= PH_DRIVE_ON && link_phase <= PH_WATCH);
        receiving = (link_phase == PH_RECEIVE || link_phase == PH_RX_ON);
        o.drive_pin = link_cfg.drive_pin_present &
                      (driving ? link_cfg.drive_active_high : ~link_cfg.drive_active_high);
        o.receive_pin = link_cfg.receive_pin_present &
                        (receiving ? link_cfg.receive_active_high : ~link_cfg.receive_active_high);
        o.launch_valid = fire_now;
        o.launch_byte = fire_now ? fire_byte : 8'h00;
        o.accepted = took;
        o.phase_now = link_phase;

        if (fire_now) launch_count++;
        if (r.action == rdc_pkg::ACT_SEND && !took) refused_count++;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Error reporting and result checking
    // ------------------------------------------------------------------
    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
            log_error($sformatf("result %0d: %s expected %0h, got %0h",
                                results_seen, name, want, got));
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        rdc_pkg::t_res want;
        rdc_pkg::t_res got;
        if (i_rst_n && status_bus.valid && status_bus.ready) begin
            got = status_bus.payload;
            if (pending_status.size() == 0) begin
                log_error($sformatf("result %0d arrived with nothing predicted", results_seen));
            end else begin
                want = pending_status.pop_front();
                check_field("drive_pin", 8'(want.drive_pin), 8'(got.drive_pin));
                check_field("receive_pin", 8'(want.receive_pin), 8'(got.receive_pin));
                check_field("launch_valid", 8'(want.launch_valid), 8'(got.launch_valid));
                check_field("launch_byte", want.launch_byte, got.launch_byte);
                check_field("accepted", 8'(want.accepted), 8'(got.accepted));
                check_field("phase_now", 8'(want.phase_now), 8'(got.phase_now));
            end
            results_seen++;
        end
    end

    // Result side: random stalls, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (status_hold)
            status_bus.ready <= 1'b0;
        else
            status_bus.ready <= steady_run || ($urandom_range(99) >= 6);
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (status_bus.valid && status_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic offer_item(input rdc_pkg::t_req r);
        while (!steady_run && $urandom_range(99) < 6) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.payload <= r;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        pending_status.push_back(advance_direction(r));
        items_sent++;
    endtask

    task automatic send_ev(input logic [1:0] act, input logic [7:0] b, input logic empty);
        rdc_pkg::t_req r;
        r.action = act;
        r.send_byte = b;
        r.transmitter_empty = empty;
        offer_item(r);
    endtask

    function automatic rdc_pkg::t_req random_item();
        rdc_pkg::t_req r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) r.action = rdc_pkg::ACT_SEND;
        else if (pick < 45) r.action = rdc_pkg::ACT_DRAIN;
        else if (pick < 95) r.action = rdc_pkg::ACT_TICK;
        else r.action = ACT_SPARE;
        r.send_byte = 8'($urandom);
        r.transmitter_empty = 1'($urandom);
        return r;
    endfunction

    // Mostly the intended event, sometimes any event at all
    task automatic noisy(input logic [1:0] act);
        rdc_pkg::t_req r;
        r.action = act;
        r.send_byte = 8'($urandom);
        r.transmitter_empty = ($urandom_range(3) != 0);
        if ($urandom_range(9) == 0) r = random_item();
        offer_item(r);
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rdc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rdc_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Writes every register; call only with nothing in flight
    task automatic apply_setup(input rdc_pkg::t_cfg c);
        write_reg(rdc_pkg::REG_DRIVE_ACTIVE_HIGH, 16'(c.drive_active_high));
        write_reg(rdc_pkg::REG_RECEIVE_ACTIVE_HIGH, 16'(c.receive_active_high));
        write_reg(rdc_pkg::REG_RELEASE_TICKS, c.release_ticks);
        write_reg(rdc_pkg::REG_TURNAROUND_TICKS, 16'(c.turnaround_ticks));
        write_reg(rdc_pkg::REG_DRIVE_PIN_PRESENT, 16'(c.drive_pin_present));
        write_reg(rdc_pkg::REG_RECEIVE_PIN_PRESENT, 16'(c.receive_pin_present));
        i_cfg_we <= 1'b0;
        link_cfg = c;
    endtask

    function automatic rdc_pkg::t_cfg random_setup();
        rdc_pkg::t_cfg c;
        c.drive_active_high = 1'($urandom);
        c.receive_active_high = 1'($urandom);
        c.drive_pin_present = ($urandom_range(9) != 0);
        c.receive_pin_present = ($urandom_range(9) != 0);
        c.turnaround_ticks = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
        c.release_ticks = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        return c;
    endfunction

    // One send burst: turn on, pass bytes, drain, wait for release
    task automatic run_session();
        int turn_len;
        turn_len = 2 * link_cfg.turnaround_ticks + 3;
        repeat ($urandom_range(1, 3)) noisy(rdc_pkg::ACT_SEND);
        repeat (turn_len) noisy(rdc_pkg::ACT_TICK);
        repeat ($urandom_range(0, 6)) noisy(rdc_pkg::ACT_SEND);
        noisy(rdc_pkg::ACT_DRAIN);
        repeat (link_cfg.release_ticks + turn_len) noisy(rdc_pkg::ACT_TICK);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: full turn-on, pass-through, watch-empty release
    task automatic test_default_sequence();
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b1);    // tick in receive mode
        send_ev(rdc_pkg::ACT_DRAIN, 8'h00, 1'b0);   // drain outside sending
        send_ev(ACT_SPARE, 8'hFF, 1'b1);            // unused action code
        send_ev(rdc_pkg::ACT_SEND, 8'h00, 1'b0);    // receiver off
        send_ev(rdc_pkg::ACT_SEND, 8'h77, 1'b0);    // refused during rx-off wait
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);    // driver on
        send_ev(rdc_pkg::ACT_SEND, 8'h11, 1'b1);    // refused during drive-on wait
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);    // held byte launches
        send_ev(rdc_pkg::ACT_SEND, 8'hFF, 1'b0);    // pass-through
        send_ev(rdc_pkg::ACT_SEND, 8'hA5, 1'b1);
        send_ev(rdc_pkg::ACT_DRAIN, 8'h00, 1'b0);   // watch transmitter empty
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_SEND, 8'h5A, 1'b0);    // cancels the release
        send_ev(rdc_pkg::ACT_DRAIN, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b1);    // empty: driver off
        send_ev(rdc_pkg::ACT_SEND, 8'h33, 1'b0);    // refused during drive-off wait
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);    // receiver on
        send_ev(rdc_pkg::ACT_SEND, 8'h44, 1'b0);    // refused during rx-on wait
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);    // back to receive
        wait_drained();
    endtask

    // Polarities, absent pins, zero and maximum waits, writes mid-wait
    task automatic test_config_extremes();
        // inverted polarity, zero turnaround: launch in the same step
        apply_setup('{drive_active_high: 1'b0, receive_active_high: 1'b1,
                      release_ticks: 16'd1, turnaround_ticks: 8'd0,
                      drive_pin_present: 1'b1, receive_pin_present: 1'b1});
        send_ev(rdc_pkg::ACT_SEND, 8'h81, 1'b0);
        send_ev(rdc_pkg::ACT_DRAIN, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b1);
        wait_drained();

        // both pins absent: waits skipped, pin fields stay low
        apply_setup('{drive_active_high: 1'b1, receive_active_high: 1'b1,
                      release_ticks: 16'd0, turnaround_ticks: 8'd7,
                      drive_pin_present: 1'b0, receive_pin_present: 1'b0});
        send_ev(rdc_pkg::ACT_SEND, 8'h7E, 1'b1);
        send_ev(rdc_pkg::ACT_DRAIN, 8'h00, 1'b1);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b1);
        wait_drained();

        // longest turnaround and longest release; send cancels the hold
        apply_setup('{drive_active_high: 1'b1, receive_active_high: 1'b0,
                      release_ticks: 16'hFFFF, turnaround_ticks: 8'hFF,
                      drive_pin_present: 1'b0, receive_pin_present: 1'b1});
        send_ev(rdc_pkg::ACT_SEND, 8'h3C, 1'b0);
        repeat (255) send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'($urandom));
        send_ev(rdc_pkg::ACT_DRAIN, 8'h00, 1'b0);
        repeat (3) send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b1);
        send_ev(rdc_pkg::ACT_SEND, 8'hC3, 1'b0);
        wait_drained();

        // registers rewritten during a turnaround wait: running count is kept
        apply_setup('{drive_active_high: 1'b1, receive_active_high: 1'b0,
                      release_ticks: 16'd4, turnaround_ticks: 8'd3,
                      drive_pin_present: 1'b1, receive_pin_present: 1'b1});
        send_ev(rdc_pkg::ACT_SEND, 8'h96, 1'b0);
        send_ev(rdc_pkg::ACT_DRAIN, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        wait_drained();
        apply_setup('{drive_active_high: 1'b1, receive_active_high: 1'b0,
                      release_ticks: 16'd1, turnaround_ticks: 8'd1,
                      drive_pin_present: 1'b1, receive_pin_present: 1'b1});
        repeat (6) send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_ev(rdc_pkg::ACT_SEND, 8'h69, 1'b1);
        repeat (3) send_ev(rdc_pkg::ACT_TICK, 8'h00, 1'b0);
        wait_drained();
    endtask

    // Result side held off while items keep coming
    task automatic test_backpressure();
        fork
            begin
                status_hold <= 1'b1;
                repeat (60) @(posedge i_clk);
                status_hold <= 1'b0;
            end
        join_none
        repeat (40) offer_item(random_item());
        wait_drained();
    endtask

    // Random send sessions under changing settings
    task automatic test_random_sessions();
        int target;
        int sessions;
        target = items_sent + RANDOM_ITEMS;
        sessions = 0;
        steady_run <= 1'b1;
        while (items_sent < target) begin
            if (sessions % 6 == 0) begin
                wait_drained();
                apply_setup(random_setup());
            end
            if (sessions == 10) steady_run <= 1'b0;
            run_session();
            sessions++;
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.payload = '0;
        status_bus.ready = 1'b0;
        status_hold = 1'b0;
        steady_run = 1'b0;
        quiet_cycles = 0;
        items_sent = 0;
        results_seen = 0;
        launch_count = 0;
        refused_count = 0;
        error_count = 0;

        // predictor starts from the reset state
        link_cfg = '{drive_active_high: 1'b1, receive_active_high: 1'b0,
                     release_ticks: 16'd0, turnaround_ticks: rdc_pkg::TURN_RESET,
                     drive_pin_present: 1'b1, receive_pin_present: 1'b1};
        link_phase = PH_RECEIVE;
        hold_count = '0;
        turn_left = '0;
        saved_byte = '0;
        sent_since_drain = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_sequence();
        test_config_extremes();
        test_backpressure();
        test_random_sessions();

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d items and %0d results: %0d launches, %0d refused sends.",
                 items_sent, results_seen, launch_count, refused_count);
        $display("Settings covered both polarities, absent pins, zero/max waits and a long stall.");
        if (error_count == 0 && pending_status.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
